FILE: rtl/core/price_level_book_macros.svh
// assertion macros shared by the price level book rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef PRICE_LEVEL_BOOK_MACROS_SVH
`define PRICE_LEVEL_BOOK_MACROS_SVH

// plain property, checked out of reset
`define PLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication
`define PLB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next cycle implication
`define PLB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/plb_pkg.sv
// types and constants of the price level book
// no dependencies
package plb_pkg;

  localparam int unsigned BookDepthDef = 16;
  localparam int unsigned PosW         = 16;
  localparam int unsigned PriceW       = 24;
  localparam int unsigned QtyW         = 24;
  localparam int unsigned CountOutW    = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_MODIFY = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } plb_op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } plb_status_e;

  typedef struct packed {
    plb_op_e           opcode;
    logic [PosW-1:0]   position;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   quantity;
  } plb_req_t;

  typedef struct packed {
    plb_status_e          status;
    logic [CountOutW-1:0] level_count;
    logic [PriceW-1:0]    read_price;
    logic [QtyW-1:0]      read_quantity;
  } plb_rsp_t;

  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   quantity;
  } plb_level_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic            ins_en;
    logic            del_en;
    logic            mod_en;
    logic [PosW-1:0] slot;
    plb_level_t      level;
  } plb_cmd_t;

endpackage

FILE: rtl/core/plb_cell.sv
// one price level of the book chain
// depends on plb_pkg
module plb_cell import plb_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  plb_cmd_t   cmd_i,
  input  plb_level_t left_i,
  input  plb_level_t right_i,
  output plb_level_t level_o,
  output plb_level_t rd_o
);

  localparam logic [PosW-1:0] MyIdx = PosW'(Idx);

  plb_level_t level_q, level_d;
  logic       hit;

  assign hit = (cmd_i.slot == MyIdx);

  always_comb begin
    level_d = level_q;
    if (cmd_i.ins_en) begin
      if (hit) begin
        level_d = cmd_i.level;
      end else if (cmd_i.slot < MyIdx) begin
        level_d = left_i;
      end
    end else if (cmd_i.del_en) begin
      if (cmd_i.slot <= MyIdx) begin
        level_d = right_i;
      end
    end else if (cmd_i.mod_en && hit) begin
      if (cmd_i.level.price != '0) begin
        level_d.price = cmd_i.level.price;
      end
      if (cmd_i.level.quantity != '0) begin
        level_d.quantity = cmd_i.level.quantity;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;
  assign rd_o    = hit ? level_q : '0;

endmodule

FILE: rtl/core/price_level_book.sv
// price level book top: command decode, level count and the chain of cells
// depends on plb_pkg, plb_cell and price_level_book_macros.svh
//
//  channel  | handshake              | payload
//  command  | start, busy            | req_i  (plb_req_t)
//  result   | out_valid_o (strobe)   | rsp_o  (plb_rsp_t)
//
// one beat per cycle: busy stays low, and the cells shift or update at the
// edge that takes the command
// the result beat comes in the cycle after its command and lasts one cycle
// reset clears the count and every cell at once
// the result port cannot stall, so nothing backs up into the command side
`include "price_level_book_macros.svh"

module price_level_book import plb_pkg::*; #(
  parameter int unsigned BookDepth = BookDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  plb_req_t req_i,
  output logic     out_valid_o,
  output plb_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(BookDepth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  plb_rsp_t        rsp_q, rsp_d;
  plb_cmd_t        cmd;
  logic            accept;
  logic [PosW-1:0] count_w;
  logic [PosW-1:0] pos_m1;
  logic            pos_past;
  logic            exists;
  logic            full;
  plb_level_t      rd_or;

  plb_level_t lvl [BookDepth];
  plb_level_t rd  [BookDepth];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign count_w = PosW'(count_q);
  assign pos_m1  = req_i.position - PosW'(1);
  assign pos_past = req_i.position > count_w;
  assign exists  = (req_i.position != '0) && !pos_past;
  assign full    = (count_q == CntW'(BookDepth));

  for (genvar g = 0; g < BookDepth; g++) begin : g_cell
    plb_level_t left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = lvl[g-1];
    end
    if (g == BookDepth - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = lvl[g+1];
    end
    plb_cell #(.Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .level_o (lvl[g]),
      .rd_o    (rd[g])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < BookDepth; i++) begin
      rd_or = rd_or | rd[i];
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.slot        = pos_m1;
    cmd.level.price = req_i.price;
    cmd.level.quantity = req_i.quantity;
    count_d         = count_q;
    rsp_d           = '0;
    rsp_d.status    = ST_DONE;
    unique case (req_i.opcode)
      OP_INSERT: begin
        if (req_i.position == '0 || req_i.price == '0 || req_i.quantity == '0) begin
          rsp_d.status = ST_IGNORED;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          cmd.ins_en = accept;
          cmd.slot   = pos_past ? count_w : pos_m1;
          count_d    = count_q + CntW'(1);
        end
      end
      OP_MODIFY: begin
        if (exists) begin
          cmd.mod_en = accept;
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      OP_DELETE: begin
        if (exists) begin
          cmd.del_en = accept;
          count_d    = count_q - CntW'(1);
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (exists) begin
          rsp_d.read_price    = rd_or.price;
          rsp_d.read_quantity = rd_or.quantity;
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      default: begin
        rsp_d.status = ST_NOT_FOUND;
      end
    endcase
    rsp_d.level_count = CountOutW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  `PLB_ASSERT(a_count_range, count_q <= CntW'(BookDepth), "level count above depth")
  `PLB_ASSERT_NXT(a_beat_follows, accept, out_valid_o, "result beat missing")
  `PLB_ASSERT_IMP(a_count_match, out_valid_o, rsp_o.level_count == CountOutW'(count_q), "count mismatch")
  `PLB_ASSERT_IMP(a_read_zero, out_valid_o && rsp_o.status != ST_DONE, rsp_o.read_price == '0 && rsp_o.read_quantity == '0, "read data on failed beat")

endmodule
